@@ rtl/core/bgc_pkg.sv @@
// Package for the button gesture classifier.
// Holds sizes, event codes and the types shared by the core modules.
// No dependencies.
package bgc_pkg;

    localparam int NUM_BUTTONS = 16;
    localparam int WORD_BITS   = 16;
    localparam int N_ACT       = (NUM_BUTTONS < WORD_BITS) ? NUM_BUTTONS : WORD_BITS;
    localparam int IDX_W       = 4;
    localparam int RAM_DEPTH   = 1 << IDX_W;
    localparam int TIMER_W     = 8;
    localparam int CNT_W       = 2;

    localparam logic [IDX_W-1:0]   IDX_LAST       = IDX_W'(N_ACT - 1);
    localparam logic [TIMER_W-1:0] LONG_PRESS_RST = 8'd50;
    localparam logic [CNT_W-1:0]   CNT_SAT        = 2'd2;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    localparam logic REG_LONG_PRESS = 1'b0;

    typedef enum logic [2:0] {
        EV_DOWN   = 3'd0,
        EV_UP     = 3'd1,
        EV_CLICK  = 3'd2,
        EV_DOUBLE = 3'd3,
        EV_LONG   = 3'd4
    } t_event;

    typedef struct packed {
        logic [TIMER_W-1:0] timer;
        logic [CNT_W-1:0]   count;
    } t_entry;

    typedef struct packed {
        logic             valid;
        t_event           kind;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_push;

    typedef struct packed {
        logic                 busy;
        logic [WORD_BITS-1:0] stable;
    } t_status;

endpackage

@@ rtl/core/bgc_ram.sv @@
// Per-button state memory: timer and click count, one entry per button.
// Registered read, one write port, per-entry valid bits so reset reads as zero.
// Depends on bgc_pkg.
module bgc_ram (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic [bgc_pkg::IDX_W-1:0] i_rd_addr,
    output bgc_pkg::t_entry          o_rd_data,
    input  logic                     i_wr_en,
    input  logic [bgc_pkg::IDX_W-1:0] i_wr_addr,
    input  bgc_pkg::t_entry          i_wr_data
);
    import bgc_pkg::*;

    t_entry               r_mem [RAM_DEPTH];
    logic [RAM_DEPTH-1:0] r_vld;
    t_entry               r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

@@ rtl/core/bgc_seq.sv @@
// Sequencer: debounce words, per-button walk over the state memory, event staging.
// Reads one entry per cycle unless the output stalls, updates it and writes it back; holds one event back to mark last.
// Depends on bgc_pkg and bgc_ram.
module bgc_seq (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic                           i_cmd,
    input  logic [bgc_pkg::WORD_BITS-1:0]  i_sample,
    input  logic [bgc_pkg::TIMER_W-1:0]    i_long_press,
    input  logic                           i_out_free,
    output bgc_pkg::t_push                 o_push,
    output bgc_pkg::t_status               o_status
);
    import bgc_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_FLUSH = 3'b100
    } t_state;

    t_state               r_state, n_state;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic                 r_tick, n_tick;
    logic [WORD_BITS-1:0] r_stable, n_stable;
    logic [WORD_BITS-1:0] r_cand, n_cand;
    logic [WORD_BITS-1:0] r_changed, n_changed;
    logic                 r_p_valid, n_p_valid;
    t_event               r_p_kind, n_p_kind;
    logic [IDX_W-1:0]     r_p_idx, n_p_idx;

    t_entry           w_entry;
    t_entry           w_new;
    logic             w_ev;
    t_event           w_kind;
    logic             w_stall;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_rd_addr;
    logic             w_acc;

    bgc_ram u_ram (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_entry),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (w_new)
    );

    assign o_ready = (r_state == ST_IDLE);
    assign w_acc   = i_valid && o_ready;

    // Update of the entry for the button at r_idx.
    always_comb begin
        w_new  = w_entry;
        w_ev   = 1'b0;
        w_kind = EV_DOWN;
        if (r_tick) begin
            if (w_entry.timer != '0) begin
                w_new.timer = w_entry.timer - TIMER_W'(1);
                if (w_entry.timer == TIMER_W'(1)) begin
                    w_ev        = 1'b1;
                    w_new.count = '0;
                    case (w_entry.count)
                        2'd0:    w_kind = EV_LONG;
                        2'd1:    w_kind = EV_CLICK;
                        default: w_kind = EV_DOUBLE;
                    endcase
                end
            end
        end else if (r_changed[r_idx]) begin
            w_ev = 1'b1;
            if (r_stable[r_idx]) begin
                w_kind = EV_UP;
                if (w_entry.timer != '0 && w_entry.count < CNT_SAT) begin
                    w_new.count = w_entry.count + CNT_W'(1);
                end
            end else begin
                w_kind = EV_DOWN;
                if (w_entry.timer == '0) begin
                    w_new.timer = i_long_press;
                end
            end
        end
    end

    assign w_stall = w_ev && r_p_valid && !i_out_free;

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_tick    = r_tick;
        n_stable  = r_stable;
        n_cand    = r_cand;
        n_changed = r_changed;
        n_p_valid = r_p_valid;
        n_p_kind  = r_p_kind;
        n_p_idx   = r_p_idx;
        o_push    = '{valid: 1'b0, kind: r_p_kind, idx: r_p_idx, last: 1'b0};
        w_wr_en   = 1'b0;
        w_rd_addr = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    n_idx = '0;
                    if (i_cmd == CMD_TICK) begin
                        n_tick  = 1'b1;
                        n_state = ST_RUN;
                    end else if (i_sample != r_stable) begin
                        if (i_sample == r_cand) begin
                            n_tick    = 1'b0;
                            n_changed = i_sample ^ r_stable;
                            n_stable  = i_sample;
                            n_state   = ST_RUN;
                        end else begin
                            n_cand = i_sample;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (w_stall) begin
                    w_rd_addr = r_idx;
                end else begin
                    w_rd_addr = r_idx + IDX_W'(1);
                    w_wr_en   = 1'b1;
                    if (w_ev) begin
                        o_push.valid = r_p_valid;
                        n_p_valid    = 1'b1;
                        n_p_kind     = w_kind;
                        n_p_idx      = r_idx;
                    end
                    n_idx = r_idx + IDX_W'(1);
                    if (r_idx == IDX_LAST) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!r_p_valid) begin
                    n_state = ST_IDLE;
                end else if (i_out_free) begin
                    o_push.valid = 1'b1;
                    o_push.last  = 1'b1;
                    n_p_valid    = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_idx     <= '0;
            r_tick    <= 1'b0;
            r_stable  <= '1;
            r_cand    <= '1;
            r_changed <= '0;
            r_p_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_tick    <= n_tick;
            r_stable  <= n_stable;
            r_cand    <= n_cand;
            r_changed <= n_changed;
            r_p_valid <= n_p_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_kind <= n_p_kind;
        r_p_idx  <= n_p_idx;
    end

    assign o_status = '{busy: (r_state != ST_IDLE), stable: r_stable};

endmodule

@@ rtl/core/button_gesture_classifier.sv @@
// Top level of the button gesture classifier: APB register, output register, sequencer.
// Depends on bgc_pkg, bgc_seq and bgc_ram.
//
// Each input transaction is a scanned word of active-low button levels (tuser 0) or a 10 ms
// tick (tuser 1). A tick, or a sample that passes the two-read debounce, walks every button
// through the per-button state memory, one button per cycle unless the output side stalls, and
// emits down, up, click, double click or long press events in index order; the final event of
// an item carries tlast. Such an item occupies the block through acceptance, the walk over all
// buttons and the flush state, and longer while the output side stalls; no new item is accepted
// until the block is idle again. A sample that is ignored or only stored as candidate leaves the
// block idle. The state memory reads as zero after reset through per-entry valid bits, so no
// clearing pass is needed. long_press_ticks sits at byte address 0 and resets to 50.
module button_gesture_classifier (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample_bits
    input  logic        s_axis_tuser,   // [0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [3:0] button_index, [7:4] zero
    output logic [2:0]  m_axis_tuser,   // [2:0] event_kind
    output logic        m_axis_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import bgc_pkg::*;

    logic [TIMER_W-1:0] r_long_press;
    logic               r_out_valid;
    t_event             r_out_kind;
    logic [IDX_W-1:0]   r_out_idx;
    logic               r_out_last;
    logic               w_out_free;
    t_push              w_push;
    t_status            w_stat;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LONG_PRESS) ? {24'b0, r_long_press} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_long_press <= LONG_PRESS_RST;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_LONG_PRESS) begin
            r_long_press <= pwdata[TIMER_W-1:0];
        end
    end

    bgc_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_sample     (s_axis_tdata),
        .i_long_press (r_long_press),
        .i_out_free   (w_out_free),
        .o_push       (w_push),
        .o_status     (w_stat)
    );

    assign w_out_free = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push.valid) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push.valid) begin
            r_out_kind <= w_push.kind;
            r_out_idx  <= w_push.idx;
            r_out_last <= w_push.last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_idx};
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tlast  = r_out_last;

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push.valid |-> w_out_free)
        else $error("event pushed into a full output register");

    a_tick_walks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_TICK) |=> !s_axis_tready)
        else $error("tick did not start a walk");

    a_same_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_SAMPLE
         && s_axis_tdata == w_stat.stable) |=> (s_axis_tready && !w_push.valid))
        else $error("unchanged sample produced work");

    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push.valid && w_push.last) |=> (s_axis_tready && !w_stat.busy))
        else $error("last event did not end the item");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for button_gesture_classifier: directed and random scan/tick streams,
// random stalls on both stream sides, APB writes of long_press_ticks between phases.
// Depends on bgc_pkg and the button_gesture_classifier RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import bgc_pkg::*;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 48;
    localparam int STALL_LIMIT     = 4000;
    localparam int MAX_PRINTED     = 50;

    typedef struct packed {
        logic                 cmd;
        logic [WORD_BITS-1:0] bits;
    } t_scan_item;

    typedef struct {
        t_event           kind;
        logic [IDX_W-1:0] idx;
        logic             last;
    } t_gesture;

    typedef enum int {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE
    } t_rx_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;    // [15:0] sample_bits
    logic        s_axis_tuser  = 1'b0;  // [0] cmd
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;          // [3:0] button_index, [7:4] zero
    logic [2:0]  m_axis_tuser;          // [2:0] event_kind
    logic        m_axis_tlast;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    // debounce and per-button gesture state
    logic [WORD_BITS-1:0] debounced = '1;
    logic [WORD_BITS-1:0] candidate = '1;
    logic [TIMER_W-1:0]   btn_timer  [N_ACT] = '{default: '0};
    logic [CNT_W-1:0]     btn_clicks [N_ACT] = '{default: '0};
    logic [TIMER_W-1:0]   hold_ticks = LONG_PRESS_RST;

    t_scan_item scan_q[$];
    t_gesture   gesture_q[$];
    logic [WORD_BITS-1:0] levels_goal = '1;

    int errors        = 0;
    int items_in      = 0;
    int ticks_in      = 0;
    int events_out    = 0;
    int settings_used = 0;
    int idle_cycles   = 0;
    int burst_left    = 0;
    int gap_left      = 0;
    int hold_left     = 0;
    int rx_mode_left  = 0;
    t_rx_mode rx_mode = RX_OPEN;
    logic hold_req    = 1'b0;
    logic hold_taken  = 1'b0;

    button_gesture_classifier DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what);
        errors++;
        if (errors <= MAX_PRINTED) $display("[%0t] mismatch: %s", $time, what);
    endtask

    function automatic void classify_item(t_scan_item it);
        t_gesture batch [N_ACT];
        logic [WORD_BITS-1:0] changed;
        int n;
        n = 0;
        if (it.cmd == CMD_TICK) begin
            for (int b = 0; b < N_ACT; b++) begin
                if (btn_timer[b] != '0) begin
                    btn_timer[b] = btn_timer[b] - TIMER_W'(1);
                    if (btn_timer[b] == '0) begin
                        batch[n].kind = (btn_clicks[b] == '0) ? EV_LONG :
                                        (btn_clicks[b] == 2'd1) ? EV_CLICK : EV_DOUBLE;
                        batch[n].idx  = IDX_W'(b);
                        batch[n].last = 1'b0;
                        n++;
                        btn_clicks[b] = '0;
                    end
                end
            end
        end else if (it.bits != debounced) begin
            if (it.bits == candidate) begin
                changed = it.bits ^ debounced;
                for (int b = 0; b < N_ACT; b++) begin
                    if (changed[b]) begin
                        batch[n].idx  = IDX_W'(b);
                        batch[n].last = 1'b0;
                        if (it.bits[b]) begin
                            batch[n].kind = EV_UP;
                            if (btn_timer[b] != '0 && btn_clicks[b] < CNT_SAT)
                                btn_clicks[b] = btn_clicks[b] + CNT_W'(1);
                        end else begin
                            batch[n].kind = EV_DOWN;
                            if (btn_timer[b] == '0) btn_timer[b] = hold_ticks;
                        end
                        n++;
                    end
                end
                debounced = it.bits;
            end else begin
                candidate = it.bits;
            end
        end
        for (int k = 0; k < n; k++) begin
            if (k == n - 1) batch[k].last = 1'b1;
            gesture_q.push_back(batch[k]);
        end
    endfunction

    function automatic void push_item(logic cmd, logic [WORD_BITS-1:0] bits);
        t_scan_item it;
        it.cmd  = cmd;
        it.bits = bits;
        scan_q.push_back(it);
    endfunction

    task automatic write_long_press(logic [TIMER_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_LONG_PRESS, 2'b00};
        pwdata  <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        hold_ticks = value;
        settings_used++;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== 32'(value))
            report_mismatch($sformatf("long_press_ticks reads %0d, wrote %0d", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic drain_and_settle();
        while (scan_q.size() != 0 || s_axis_tvalid || gesture_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly debounced press/release traffic on a few hot buttons, mixed with ticks and noise.
    task automatic queue_random(int count);
        logic [WORD_BITS-1:0] want;
        logic [WORD_BITS-1:0] noise;
        logic [WORD_BITS-1:0] mask;
        int pick;
        levels_goal = debounced;
        for (int k = 0; k < count; k++) begin
            pick  = $urandom_range(0, 99);
            noise = WORD_BITS'($urandom);
            if (pick < 35) begin
                push_item(CMD_TICK, noise);
            end else if (pick < 80) begin
                if ($urandom_range(0, 7) == 0) begin
                    mask = WORD_BITS'($urandom);
                end else begin
                    mask = WORD_BITS'(1) << (($urandom_range(0, 3) != 0) ?
                           $urandom_range(0, 3) : $urandom_range(0, 15));
                    if ($urandom_range(0, 3) == 0)
                        mask = mask | (WORD_BITS'(1) << $urandom_range(0, 15));
                end
                want = levels_goal ^ mask;
                if (pick >= 72) push_item(CMD_SAMPLE, noise);
                push_item(CMD_SAMPLE, want);
                push_item(CMD_SAMPLE, want);
                levels_goal = want;
            end else if (pick < 90) begin
                push_item(CMD_SAMPLE, noise);
            end else begin
                push_item(CMD_SAMPLE, levels_goal);
            end
        end
    endtask

    always @(posedge i_clk) begin : drive_scan
        t_scan_item it;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                it.cmd  = s_axis_tuser;
                it.bits = s_axis_tdata;
                classify_item(it);
                items_in++;
                if (it.cmd == CMD_TICK) ticks_in++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (scan_q.size() > 0) begin
                    it = scan_q.pop_front();
                    s_axis_tuser  <= it.cmd;
                    s_axis_tdata  <= it.bits;
                    s_axis_tvalid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(0, 23);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : drive_ready
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_OFF_CYCLES;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 2));
                rx_mode_left = $urandom_range(20, 80);
            end else begin
                rx_mode_left--;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                case (rx_mode)
                    RX_OPEN: m_axis_tready <= 1'b1;
                    RX_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
                    default: m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : check_events
        t_gesture want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            events_out++;
            if (gesture_q.size() == 0) begin
                report_mismatch($sformatf("unexpected event kind %0d button %0d",
                                          m_axis_tuser, m_axis_tdata));
            end else begin
                want = gesture_q.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch($sformatf("button %0d: kind %0d, want %0d",
                                              want.idx, m_axis_tuser, want.kind));
                if (m_axis_tdata !== {4'b0000, want.idx})
                    report_mismatch($sformatf("index field %0d, want %0d",
                                              m_axis_tdata, want.idx));
                if (m_axis_tlast !== want.last)
                    report_mismatch($sformatf("button %0d: tlast %0b, want %0b",
                                              want.idx, m_axis_tlast, want.last));
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (psel && penable)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("button_gesture_classifier verification failed");
                $finish;
            end
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_long_press(8'd3);
        push_item(CMD_SAMPLE, 16'hFFFF);
        push_item(CMD_TICK,   16'hA5A5);
        push_item(CMD_SAMPLE, 16'h0000);
        push_item(CMD_SAMPLE, 16'h0000);
        repeat (3) push_item(CMD_TICK, 16'h5A5A);
        push_item(CMD_SAMPLE, 16'hFFFF);
        push_item(CMD_SAMPLE, 16'hFFFF);
        // press 0 and 15, release 0, tick once
        push_item(CMD_SAMPLE, 16'h7FFE);
        push_item(CMD_SAMPLE, 16'h7FFE);
        push_item(CMD_SAMPLE, 16'h7FFF);
        push_item(CMD_SAMPLE, 16'h7FFF);
        push_item(CMD_TICK,   16'h0000);
        // release 15 after a glitch, then two more press/release rounds to saturate the count
        push_item(CMD_SAMPLE, 16'h1234);
        push_item(CMD_SAMPLE, 16'hFFFF);
        push_item(CMD_SAMPLE, 16'hFFFF);
        repeat (2) begin
            push_item(CMD_SAMPLE, 16'h7FFF);
            push_item(CMD_SAMPLE, 16'h7FFF);
            push_item(CMD_SAMPLE, 16'hFFFF);
            push_item(CMD_SAMPLE, 16'hFFFF);
        end
        repeat (2) push_item(CMD_TICK, 16'hFFFF);
        drain_and_settle();

        write_long_press(8'd1);
        queue_random(30);
        @(posedge i_clk);
        hold_req <= 1'b1;
        drain_and_settle();

        write_long_press(8'd255);
        queue_random(8);
        repeat (256) push_item(CMD_TICK, WORD_BITS'($urandom));
        drain_and_settle();

        repeat (2) begin
            write_long_press(TIMER_W'($urandom_range(2, 6)));
            queue_random(10);
            drain_and_settle();
        end

        $display("Run covered %0d input transactions (%0d ticks) and %0d gesture events",
                 items_in, ticks_in, events_out);
        $display("across %0d long-press settings, from 1 to 255 ticks", settings_used);
        if (errors == 0) begin
            $display("button_gesture_classifier verification clean");
        end else begin
            $display("button_gesture_classifier verification failed");
        end
        $finish;
    end

endmodule
